### sv/llt_pkg.sv
// ----------------------------------------------------------------------------
// llt_pkg: shared types and constants for the lambda language tokenizer
// Token kinds, operator codes, lexer modes, keyword table and result records.
// ----------------------------------------------------------------------------
package llt_pkg;

  // longest identifier that is echoed byte by byte
  localparam int unsigned MAX_WORD_LEN = 63;

  // number of keywords and length of the stored identifier prefix
  localparam int unsigned NUM_KW    = 8;
  localparam int unsigned KW_BYTES  = 5;

  // token kinds
  localparam logic [4:0] K_EOF    = 5'd0;
  localparam logic [4:0] K_INT    = 5'd1;
  localparam logic [4:0] K_IDENT  = 5'd2;
  localparam logic [4:0] K_KW_LET = 5'd3;
  localparam logic [4:0] K_LAMBDA = 5'd11;
  localparam logic [4:0] K_DOT    = 5'd12;
  localparam logic [4:0] K_LPAREN = 5'd13;
  localparam logic [4:0] K_RPAREN = 5'd14;
  localparam logic [4:0] K_EQ     = 5'd15;
  localparam logic [4:0] K_COLON  = 5'd16;
  localparam logic [4:0] K_ARROW  = 5'd17;
  localparam logic [4:0] K_SEMI   = 5'd18;
  localparam logic [4:0] K_OP     = 5'd19;
  localparam logic [4:0] K_ERROR  = 5'd20;
  localparam logic [4:0] K_TEXT   = 5'd21;

  // operator codes for kind op
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_MUL = 3'd1;
  localparam logic [2:0] OP_SUB = 3'd2;
  localparam logic [2:0] OP_EQ  = 3'd3;
  localparam logic [2:0] OP_LT  = 3'd4;
  localparam logic [2:0] OP_LE  = 3'd5;
  localparam logic [2:0] OP_GT  = 3'd6;
  localparam logic [2:0] OP_GE  = 3'd7;

  // token in progress
  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_NUM     = 3'd1,
    MODE_WORD    = 3'd2,
    MODE_COMMENT = 3'd3,
    MODE_EQ      = 3'd4,
    MODE_MINUS   = 3'd5,
    MODE_LT      = 3'd6,
    MODE_GT      = 3'd7
  } lex_mode_e;

  // keyword spellings, first byte in the low bits
  localparam logic [8*KW_BYTES-1:0] KW_PREFIX [NUM_KW] = '{
    40'h00_0074_656c,  // let
    40'h00_0063_6572,  // rec
    40'h00_0000_6e69,  // in
    40'h00_0000_6669,  // if
    40'h00_6e65_6874,  // then
    40'h00_6573_6c65,  // else
    40'h00_6575_7274,  // true
    40'h65_736c_6166   // false
  };
  localparam logic [5:0] KW_LEN [NUM_KW] = '{
    6'd3, 6'd3, 6'd2, 6'd2, 6'd4, 6'd4, 6'd4, 6'd5
  };

  // one result record
  typedef struct packed {
    logic [4:0]  kind;
    logic [2:0]  op_code;
    logic        at_line_start;
    logic [63:0] number;
    logic [7:0]  text_byte;
    logic [5:0]  text_index;
  } res_t;

  // all results caused by one input beat
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

  // class a finished identifier as keyword or plain identifier
  function automatic logic [4:0] kw_kind(logic [8*KW_BYTES-1:0] pre, logic [5:0] len);
    logic [4:0] k;
    k = K_IDENT;
    for (int i = 0; i < NUM_KW; i++) begin
      if (KW_LEN[i] == len && KW_PREFIX[i] == pre) begin
        k = K_KW_LET + 5'(i);
      end
    end
    return k;
  endfunction

endpackage

### sv/lambda_language_tokenizer.sv
// ----------------------------------------------------------------------------
// lambda_language_tokenizer: streaming lexer for a small lambda language
// Turns source bytes into tokens and identifier text records.
// ----------------------------------------------------------------------------
// One source byte is taken per cycle while stall_o is low. Each byte causes
// zero, one or two result beats; all of them are computed in the cycle the
// byte is taken and written as one entry into a two-entry result queue. The
// block sustains one byte per cycle while the output side takes a beat every
// cycle and no byte causes two results; a byte that causes two results is
// sent as two beats, last_o marking the second. stall_o rises while both
// queue entries are occupied. Byte 0 ends a source and emits EOF; a new
// source may follow at once.
module lambda_language_tokenizer
  import llt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [7:0]         ch_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic [4:0]         kind_o,
  output logic [2:0]         op_code_o,
  output logic               at_line_start_o,
  output logic signed [63:0] number_o,
  output logic [7:0]         text_byte_o,
  output logic [5:0]         text_index_o,
  output logic               last_o
);

  // lexer state
  lex_mode_e                mode_q, mode_d;
  logic                     nl_q, nl_d;
  logic [63:0]              acc_q, acc_d;
  logic [8*KW_BYTES-1:0]    pre_q, pre_d;
  logic [5:0]               len_q, len_d;

  // result queue
  entry_t     fifo_q [2];
  logic       wr_q, rd_q, sub_q;
  logic [1:0] cnt_q;

  logic   in_acc, push, pop, out_acc;
  logic   fv, f_tok, go_start, sv, nl_mid, is_dig, is_alpha;
  logic [3:0] dig;
  res_t   f, s;
  entry_t ent;
  res_t   cur;

  assign in_acc = valid_i && !stall_o;
  assign stall_o = (cnt_q == 2'd2);

  // byte classes
  assign is_dig   = (ch_i >= "0") && (ch_i <= "9");
  assign is_alpha = ((ch_i >= "a") && (ch_i <= "z")) || ((ch_i >= "A") && (ch_i <= "Z")) ||
                    (ch_i == "_");
  assign dig      = 4'(ch_i - 8'h30);

  // next state and results for one byte
  always_comb begin
    mode_d   = mode_q;
    nl_d     = nl_q;
    acc_d    = acc_q;
    pre_d    = pre_q;
    len_d    = len_q;
    fv       = 1'b0;
    f_tok    = 1'b0;
    go_start = 1'b0;
    f        = '0;
    f.at_line_start = nl_q;

    // finish or extend the token in progress
    unique case (mode_q)
      MODE_NUM: begin
        if (is_dig) begin
          acc_d = (acc_q << 3) + (acc_q << 1) + {60'b0, dig};
        end else begin
          fv       = 1'b1;
          f_tok    = 1'b1;
          f.kind   = K_INT;
          f.number = acc_q;
          go_start = 1'b1;
        end
      end
      MODE_WORD: begin
        if (is_alpha || is_dig) begin
          if (len_q < 6'(KW_BYTES)) begin
            pre_d = pre_q | ((8*KW_BYTES)'(ch_i) << {len_q[2:0], 3'b000});
          end
          if (len_q < 6'(MAX_WORD_LEN)) begin
            fv           = 1'b1;
            f.kind       = K_TEXT;
            f.text_byte  = ch_i;
            f.text_index = len_q;
            len_d        = len_q + 6'd1;
          end
        end else begin
          fv       = 1'b1;
          f_tok    = 1'b1;
          f.kind   = kw_kind(pre_q, len_q);
          go_start = 1'b1;
        end
      end
      MODE_COMMENT: begin
        go_start = (ch_i == 8'h00) || (ch_i == 8'h0a);
      end
      MODE_EQ: begin
        fv    = 1'b1;
        f_tok = 1'b1;
        if (ch_i == "=") begin
          f.kind    = K_OP;
          f.op_code = OP_EQ;
          mode_d    = MODE_IDLE;
        end else begin
          f.kind   = K_EQ;
          go_start = 1'b1;
        end
      end
      MODE_MINUS: begin
        if (ch_i == "-") begin
          mode_d = MODE_COMMENT;
        end else if (ch_i == ">") begin
          fv     = 1'b1;
          f_tok  = 1'b1;
          f.kind = K_ARROW;
          mode_d = MODE_IDLE;
        end else begin
          fv        = 1'b1;
          f_tok     = 1'b1;
          f.kind    = K_OP;
          f.op_code = OP_SUB;
          go_start  = 1'b1;
        end
      end
      MODE_LT, MODE_GT: begin
        fv     = 1'b1;
        f_tok  = 1'b1;
        f.kind = K_OP;
        if (ch_i == "=") begin
          f.op_code = (mode_q == MODE_LT) ? OP_LE : OP_GE;
          mode_d    = MODE_IDLE;
        end else begin
          f.op_code = (mode_q == MODE_LT) ? OP_LT : OP_GT;
          go_start  = 1'b1;
        end
      end
      default: begin
        go_start = 1'b1;
      end
    endcase

    // a finished token clears the newline flag
    nl_mid = f_tok ? 1'b0 : nl_q;
    nl_d   = nl_mid;

    // treat the byte as the start of the next token
    sv = 1'b0;
    s  = '0;
    s.at_line_start = nl_mid;
    if (go_start) begin
      mode_d = MODE_IDLE;
      if (ch_i == 8'h00) begin
        sv     = 1'b1;
        s.kind = K_EOF;
        nl_d   = 1'b0;
      end else if (ch_i == 8'h0a) begin
        nl_d = 1'b1;
      end else if ((ch_i == " ") || (ch_i == 8'h09) || (ch_i == 8'h0d)) begin
        nl_d = nl_mid;
      end else if (is_dig) begin
        mode_d = MODE_NUM;
        acc_d  = {60'b0, dig};
      end else if (is_alpha) begin
        mode_d       = MODE_WORD;
        pre_d        = (8*KW_BYTES)'(ch_i);
        len_d        = 6'd1;
        sv           = 1'b1;
        s.kind       = K_TEXT;
        s.text_byte  = ch_i;
        s.text_index = 6'd0;
      end else begin
        sv   = 1'b1;
        nl_d = 1'b0;
        case (ch_i)
          8'h5c:   s.kind = K_LAMBDA;
          ".":     s.kind = K_DOT;
          "(":     s.kind = K_LPAREN;
          ")":     s.kind = K_RPAREN;
          ":":     s.kind = K_COLON;
          ";":     s.kind = K_SEMI;
          "+": begin
            s.kind    = K_OP;
            s.op_code = OP_ADD;
          end
          "*": begin
            s.kind    = K_OP;
            s.op_code = OP_MUL;
          end
          "=": begin
            sv     = 1'b0;
            nl_d   = nl_mid;
            mode_d = MODE_EQ;
          end
          "-": begin
            sv     = 1'b0;
            nl_d   = nl_mid;
            mode_d = MODE_MINUS;
          end
          "<": begin
            sv     = 1'b0;
            nl_d   = nl_mid;
            mode_d = MODE_LT;
          end
          ">": begin
            sv     = 1'b0;
            nl_d   = nl_mid;
            mode_d = MODE_GT;
          end
          default: begin
            s.kind      = K_ERROR;
            s.text_byte = ch_i;
          end
        endcase
      end
    end

    // pack the results of this byte into one queue entry
    ent = '0;
    if (fv) begin
      ent.r0  = f;
      ent.r1  = s;
      ent.two = sv;
    end else begin
      ent.r0 = s;
    end
  end

  assign push = in_acc && (fv || sv);

  // lexer state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      nl_q   <= 1'b0;
      acc_q  <= '0;
      pre_q  <= '0;
      len_q  <= '0;
    end else if (in_acc) begin
      mode_q <= mode_d;
      nl_q   <= nl_d;
      acc_q  <= acc_d;
      pre_q  <= pre_d;
      len_q  <= len_d;
    end
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= ent;
    end
  end

  // output side
  assign valid_o = (cnt_q != 2'd0);
  assign cur     = sub_q ? fifo_q[rd_q].r1 : fifo_q[rd_q].r0;
  assign last_o  = sub_q || !fifo_q[rd_q].two;
  assign out_acc = valid_o && !stall_i;
  assign pop     = out_acc && last_o;

  assign kind_o          = cur.kind;
  assign op_code_o       = cur.op_code;
  assign at_line_start_o = cur.at_line_start;
  assign number_o        = signed'(cur.number);
  assign text_byte_o     = cur.text_byte;
  assign text_index_o    = cur.text_index;

  // queue pointers and beat counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      sub_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= !wr_q;
      end
      if (out_acc) begin
        if (last_o) begin
          rd_q  <= !rd_q;
          sub_q <= 1'b0;
        end else begin
          sub_q <= 1'b1;
        end
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

`ifndef SYNTHESIS
  // queue never holds more than two entries
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result queue overflow");

  // an identifier in progress always has at least one byte
  a_word_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_WORD) |-> (len_q != 6'd0))
    else $error("empty identifier in word mode");

  // end of source returns to idle with no pending newline
  a_eof_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (ch_i == 8'h00)) |=> ((mode_q == MODE_IDLE) && !nl_q))
    else $error("lexer not idle after end of source");
`endif

endmodule
